// ----- hw/rtl/bfca_pkg.sv -----
package bfca_pkg;

  localparam int TABLE_SLOTS = 64;
  localparam int ENTRY_DEPTH = TABLE_SLOTS - 1;
  localparam int IDX_W = $clog2(TABLE_SLOTS);
  localparam int CNT_W = $clog2(TABLE_SLOTS + 1);

  localparam logic [2:0] ST_ALLOCATED = 3'd0;
  localparam logic [2:0] ST_FREED     = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_NO_SPACE  = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [1:0] CFG_HEAP_BASE = 2'd0;
  localparam logic [1:0] CFG_HEAP_SIZE = 2'd1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND_RD,
    S_FIND_CHK,
    S_SCAN_RD,
    S_SCAN_ACC,
    S_DECIDE,
    S_FIT_RD,
    S_FIT_ACC,
    S_PLACE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_COMMIT,
    S_RESULT
  } ctl_state_t;

  typedef struct packed {
    logic load_req;
    logic rd_en;
    logic shift_rd;
    logic clr_acc;
    logic find_chk;
    logic scan_acc;
    logic decide;
    logic fit_acc;
    logic place;
    logic shift_wr;
    logic commit;
    logic set_out;
    logic idx_inc;
    logic idx_dec;
  } dp_cmd_t;

  typedef struct packed {
    logic is_free;
    logic idx_at_end;
    logic idx_at_pos;
    logic found;
    logic full;
    logic no_space;
    logic at_base;
  } dp_sts_t;

endpackage

// ----- hw/rtl/bfca_ctrl.sv -----
module bfca_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output bfca_pkg::dp_cmd_t cmd,
  input  bfca_pkg::dp_sts_t sts
);
  import bfca_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_tvalid && in_tready) state_nxt = S_FIND_RD;
      S_FIND_RD: begin
        if (sts.idx_at_end) begin
          if (sts.is_free) state_nxt = S_COMMIT;
          else if (sts.full) state_nxt = S_COMMIT;
          else state_nxt = S_DECIDE;
        end else if (sts.is_free) state_nxt = S_FIND_CHK;
        else state_nxt = S_SCAN_ACC;
      end
      S_FIND_CHK: state_nxt = sts.found ? S_SHIFT_RD : S_FIND_RD;
      S_SCAN_RD:  state_nxt = S_SCAN_ACC;
      S_SCAN_ACC: state_nxt = S_FIND_RD;
      S_DECIDE: begin
        if (sts.no_space || sts.at_base) state_nxt = S_PLACE;
        else state_nxt = S_FIT_RD;
      end
      S_FIT_RD:   state_nxt = sts.idx_at_end ? S_PLACE : S_FIT_ACC;
      S_FIT_ACC:  state_nxt = S_FIT_RD;
      S_PLACE:    state_nxt = sts.no_space ? S_COMMIT : S_SHIFT_RD;
      S_SHIFT_RD: state_nxt = sts.idx_at_pos ? S_COMMIT : S_SHIFT_WR;
      S_SHIFT_WR: state_nxt = S_SHIFT_RD;
      S_COMMIT:   state_nxt = S_RESULT;
      S_RESULT:   state_nxt = out_free ? S_IDLE : S_RESULT;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE:     begin cmd.load_req = in_tvalid && in_tready; cmd.clr_acc = 1'b1; end
      S_FIND_RD:  cmd.rd_en = !sts.idx_at_end;
      S_FIND_CHK: begin cmd.find_chk = 1'b1; cmd.idx_inc = !sts.found; end
      S_SCAN_RD:  cmd.rd_en = 1'b1;
      S_SCAN_ACC: begin cmd.scan_acc = 1'b1; cmd.idx_inc = 1'b1; end
      S_DECIDE:   cmd.decide = 1'b1;
      S_FIT_RD:   cmd.rd_en = !sts.idx_at_end;
      S_FIT_ACC:  begin cmd.fit_acc = 1'b1; cmd.idx_inc = 1'b1; end
      S_PLACE:    cmd.place = 1'b1;
      S_SHIFT_RD: begin cmd.rd_en = !sts.idx_at_pos; cmd.shift_rd = !sts.idx_at_pos; end
      S_SHIFT_WR: begin cmd.shift_wr = 1'b1; cmd.idx_dec = !sts.is_free;
                        cmd.idx_inc = sts.is_free; end
      S_COMMIT:   cmd.commit = 1'b1;
      S_RESULT:   cmd.set_out = out_free;
      default:    cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (state_r == S_RESULT && out_free) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTH
  a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RESULT |=> out_valid_r) else $error("result not presented");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_tready) else $error("accept while busy");
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r) else $error("result dropped");
`endif
endmodule

// ----- hw/rtl/bfca_dp.sv -----
module bfca_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  bfca_pkg::dp_cmd_t cmd,
  output bfca_pkg::dp_sts_t sts,
  input  logic              req_type,
  input  logic [31:0]       alloc_size,
  input  logic [31:0]       free_address,
  input  logic              cfg_we,
  input  logic [31:0]       heap_size,
  input  logic [31:0]       heap_base,
  output logic [2:0]        status,
  output logic [31:0]       chunk_address,
  output logic [31:0]       freed_bytes
);
  import bfca_pkg::*;

  logic [31:0] mem_addr [ENTRY_DEPTH];
  logic [31:0] mem_size [ENTRY_DEPTH];
  logic [31:0] rd_addr_r, rd_size_r;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic [31:0] free_r, free_nxt;
  logic        type_r;
  logic [32:0] need_r;
  logic [31:0] key_r;
  logic [32:0] prev_end_r, prev_end_nxt;
  logic [33:0] sum_r, sum_nxt;
  logic [32:0] big_r, big_nxt;
  logic        big0_r, big0_nxt;
  logic        fnd_r, fnd_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [32:0] addr_r, addr_nxt;
  logic [31:0] fsz_r;
  logic [2:0]  st_r, st_nxt;
  logic        nosp_r, nosp_nxt;
  logic        atb_r, atb_nxt;
  logic [2:0]  status_r;
  logic [31:0] caddr_r, fbytes_r;

  logic [32:0] cur_end, gap, gapf, tail, largest;
  logic        wr_en;
  logic [IDX_W-1:0] wr_idx, rd_idx;
  logic [31:0] wr_a, wr_s;
  logic [CNT_W-1:0] rd_sel;

  assign cur_end = {1'b0, rd_addr_r} + {1'b0, rd_size_r};
  assign gap  = ({1'b0, rd_addr_r} > prev_end_r) ? {1'b0, rd_addr_r} - prev_end_r : '0;
  assign gapf = (rd_addr_r > rd_addr_r) ? '0 : gap;
  assign tail = ({2'b0, free_r} > sum_r) ? 33'({2'b0, free_r} - sum_r) : '0;
  assign largest = (tail > big_r) ? tail : big_r;

  assign sts.is_free    = type_r;
  assign sts.idx_at_end = (idx_r == count_r);
  assign sts.idx_at_pos = type_r ? (idx_r + 1'b1 >= count_r) : (idx_r == pos_r);
  assign sts.found      = (rd_addr_r == key_r);
  assign sts.full       = (count_r >= CNT_W'(ENTRY_DEPTH));
  assign sts.no_space   = nosp_r;
  assign sts.at_base    = atb_r;

  // free shifts down reading idx+1, alloc shifts up reading idx-1
  assign rd_sel = !cmd.shift_rd ? idx_r : (type_r ? idx_r + 1'b1 : idx_r - 1'b1);
  assign rd_idx = rd_sel[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_addr_r <= mem_addr[rd_idx];
      rd_size_r <= mem_size[rd_idx];
    end
    if (wr_en) begin
      mem_addr[wr_idx] <= wr_a;
      mem_size[wr_idx] <= wr_s;
    end
  end

  always_comb begin
    wr_en  = 1'b0;
    wr_idx = idx_r[IDX_W-1:0];
    wr_a   = rd_addr_r;
    wr_s   = rd_size_r;
    if (cmd.shift_wr) wr_en = 1'b1;
    if (cmd.commit && !type_r && !sts.full && st_r == ST_ALLOCATED) begin
      wr_en  = 1'b1;
      wr_idx = pos_r[IDX_W-1:0];
      wr_a   = addr_r[31:0];
      wr_s   = need_r[31:0];
    end
  end

  always_comb begin
    count_nxt = count_r; idx_nxt = idx_r; pos_nxt = pos_r; free_nxt = free_r;
    prev_end_nxt = prev_end_r; sum_nxt = sum_r; big_nxt = big_r; big0_nxt = big0_r;
    fnd_nxt = fnd_r; rem_nxt = rem_r; addr_nxt = addr_r; st_nxt = st_r;
    nosp_nxt = nosp_r; atb_nxt = atb_r;
    if (cmd.idx_inc) idx_nxt = idx_r + 1'b1;
    if (cmd.idx_dec) idx_nxt = idx_r - 1'b1;
    if (cmd.clr_acc) begin
      idx_nxt = '0; prev_end_nxt = {1'b0, heap_base}; sum_nxt = '0; big_nxt = '0;
      big0_nxt = 1'b0; fnd_nxt = 1'b0; rem_nxt = '0; st_nxt = ST_ALLOCATED;
      nosp_nxt = 1'b0; atb_nxt = 1'b0; addr_nxt = {1'b0, heap_base};
    end
    if (cmd.scan_acc) begin
      sum_nxt = sum_r[33] ? sum_r : sum_r + {1'b0, gap};
      if (gap > big_r) begin
        big_nxt = gap; big0_nxt = (idx_r == '0);
      end
      prev_end_nxt = cur_end;
      addr_nxt = cur_end;
    end
    if (cmd.decide) begin
      nosp_nxt = need_r[32] || (largest < need_r);
      atb_nxt  = big0_r && (big_r >= need_r);
      idx_nxt  = '0;
      prev_end_nxt = {1'b0, heap_base};
      pos_nxt  = count_r;
      if (count_r == '0) addr_nxt = {1'b0, heap_base};
    end
    if (cmd.fit_acc) begin
      if (idx_r != '0 && gapf >= need_r && (!fnd_r || gapf - need_r < rem_r)) begin
        fnd_nxt = 1'b1; rem_nxt = gapf - need_r; pos_nxt = idx_r;
        addr_nxt = prev_end_r;
      end
      prev_end_nxt = cur_end;
    end
    if (cmd.place) begin
      if (nosp_r) st_nxt = ST_NO_SPACE;
      else if (atb_r) begin pos_nxt = '0; addr_nxt = {1'b0, heap_base}; end
      idx_nxt = count_r;
    end
    if (cmd.commit) begin
      if (type_r) begin
        if (st_r == ST_FREED) begin
          count_nxt = count_r - 1'b1;
          free_nxt = (free_r > 32'hFFFF_FFFF - fsz_r) ? 32'hFFFF_FFFF : free_r + fsz_r;
        end else st_nxt = ST_NOT_FOUND;
      end else if (sts.full) st_nxt = ST_FULL;
      else if (st_r == ST_ALLOCATED) begin
        count_nxt = count_r + 1'b1;
        free_nxt = ({1'b0, free_r} > need_r) ? 32'({1'b0, free_r} - need_r) : '0;
      end
    end
    if (cmd.find_chk && sts.found) st_nxt = ST_FREED;
    if (cmd.find_chk && !sts.found) st_nxt = ST_NOT_FOUND;
    if (cfg_we) begin count_nxt = '0; free_nxt = heap_size; end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      type_r <= req_type;
      need_r <= ({1'b0, alloc_size} + 33'd3) & ~33'd3;
      key_r  <= free_address;
    end
    if (cmd.find_chk && sts.found) fsz_r <= rd_size_r;
    prev_end_r <= prev_end_nxt; sum_r <= sum_nxt; big_r <= big_nxt; big0_r <= big0_nxt;
    fnd_r <= fnd_nxt; rem_r <= rem_nxt; addr_r <= addr_nxt; pos_r <= pos_nxt;
    nosp_r <= nosp_nxt; atb_r <= atb_nxt;
    if (cmd.set_out) begin
      status_r <= st_r;
      caddr_r  <= (st_r == ST_ALLOCATED) ? addr_r[31:0] : '0;
      fbytes_r <= (st_r == ST_FREED) ? fsz_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0; free_r <= '0; idx_r <= '0; st_r <= ST_ALLOCATED;
    end else begin
      count_r <= count_nxt; free_r <= free_nxt; idx_r <= idx_nxt; st_r <= st_nxt;
    end
  end

  assign status = status_r;
  assign chunk_address = caddr_r;
  assign freed_bytes = fbytes_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(ENTRY_DEPTH)) else $error("table overrun");
  a_commit_grow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && !type_r && st_r == ST_ALLOCATED && !sts.full && !cfg_we
    |=> count_r == $past(count_r) + 1'b1) else $error("insert lost");
  a_commit_shrink: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && type_r && st_r == ST_FREED && !cfg_we
    |=> count_r == $past(count_r) - 1'b1) else $error("remove lost");
`endif
endmodule

// ----- hw/rtl/best_fit_chunk_allocator.sv -----
// Best-fit allocator for one heap region. Configure heap_base (0x0) and heap_size (0x4) over
// the APB port while idle; either write clears the chunk table. Each request returns one
// result. A request walks the chunk table (up to 63 stored chunks) through its one memory
// read port in scan, fit and shift passes.
module best_fit_chunk_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // req_type, alloc_size, free_address, pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // status, chunk_address, freed_bytes, pad
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import bfca_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic [31:0] base_r, size_r;
  logic cfg_we;
  logic [2:0] status;
  logic [31:0] caddr, fbytes;

  assign cfg_pready = 1'b1;
  assign cfg_we = cfg_psel && cfg_penable && cfg_pwrite &&
                  (cfg_paddr[2] == CFG_HEAP_BASE[0] || cfg_paddr[2] == CFG_HEAP_SIZE[0]);
  assign cfg_prdata = (cfg_paddr[2] == CFG_HEAP_SIZE[0]) ? size_r : base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      size_r <= '0;
    end else if (cfg_we) begin
      if (cfg_paddr[2] == CFG_HEAP_BASE[0]) base_r <= cfg_pwdata;
      else size_r <= cfg_pwdata;
    end
  end

  bfca_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .cmd, .sts
  );

  bfca_dp u_dp (
    .clk, .rst_n, .cmd, .sts,
    .req_type(in_tdata[0]), .alloc_size(in_tdata[32:1]), .free_address(in_tdata[64:33]),
    .cfg_we, .heap_size(cfg_paddr[2] ? cfg_pwdata : size_r),
    .heap_base(base_r),
    .status, .chunk_address(caddr), .freed_bytes(fbytes)
  );

  assign out_tdata = {5'd0, fbytes, caddr, status};
endmodule

// ----- bench/testbench.sv -----
module testbench;
  import bfca_pkg::*;

  typedef struct {
    logic        kind;
    logic [31:0] size;
    logic [31:0] addr;
  } request_t;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] chunk_addr;
    logic [31:0] freed;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;   // req_type, alloc_size, free_address, pad
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;  // status, chunk_address, freed_bytes, pad
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  best_fit_chunk_allocator dut (.*);

  request_t pending_q[$];
  reply_t   reply_q[$];

  // allocator state as the block should hold it
  logic [31:0] heap_base_r;
  logic [31:0] heap_size_r;
  logic [31:0] chunk_addr[ENTRY_DEPTH];
  logic [31:0] chunk_len[ENTRY_DEPTH];
  int          chunk_cnt;
  logic [31:0] free_bytes;

  bit fail = 1'b0;
  int status_seen[5];
  int config_writes;
  logic long_hold_req;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] gap_before(int k);
    logic [63:0] prev;
    logic [63:0] a;
    prev = (k == 0) ? {32'b0, heap_base_r} : {32'b0, chunk_addr[k-1]} + {32'b0, chunk_len[k-1]};
    a = {32'b0, chunk_addr[k]};
    return (a > prev) ? a - prev : 64'd0;
  endfunction

  function automatic reply_t predict_allocator(request_t r);
    reply_t      res;
    logic [63:0] need, sum, biggest, tail, largest, g, rem, best_rem, place;
    int          big_idx, best_k, pos;
    bit          has_big, found;
    res = '{status: ST_NOT_FOUND, chunk_addr: 0, freed: 0};
    if (r.kind == REQ_FREE) begin
      for (int k = 0; k < chunk_cnt; k++) begin
        if (chunk_addr[k] == r.addr) begin
          res.status = ST_FREED;
          res.freed = chunk_len[k];
          for (int j = k; j + 1 < chunk_cnt; j++) begin
            chunk_addr[j] = chunk_addr[j+1];
            chunk_len[j] = chunk_len[j+1];
          end
          chunk_cnt--;
          free_bytes = (free_bytes > 32'hFFFF_FFFF - res.freed) ? 32'hFFFF_FFFF
                                                               : free_bytes + res.freed;
          return res;
        end
      end
      return res;
    end
    if (chunk_cnt >= ENTRY_DEPTH) begin
      res.status = ST_FULL;
      return res;
    end
    need = ({32'b0, r.size} + 64'd3) & ~64'd3;
    sum = 0; biggest = 0; big_idx = 0; has_big = 0;
    for (int k = 0; k < chunk_cnt; k++) begin
      g = gap_before(k);
      sum += g;
      if (g > biggest) begin
        biggest = g; big_idx = k; has_big = 1;
      end
    end
    tail = ({32'b0, free_bytes} > sum) ? {32'b0, free_bytes} - sum : 64'd0;
    largest = (tail > biggest) ? tail : biggest;
    if (need > 64'hFFFF_FFFF || largest < need) begin
      res.status = ST_NO_SPACE;
      return res;
    end
    found = 0; best_k = 0; best_rem = 0;
    if (has_big && big_idx == 0 && biggest >= need) begin
      pos = 0;
      place = {32'b0, heap_base_r};
    end else begin
      for (int k = 0; k + 1 < chunk_cnt; k++) begin
        g = gap_before(k + 1);
        if (g >= need) begin
          rem = g - need;
          if (!found || rem < best_rem) begin
            found = 1; best_rem = rem; best_k = k;
          end
        end
      end
      if (found) begin
        pos = best_k + 1;
        place = {32'b0, chunk_addr[best_k]} + {32'b0, chunk_len[best_k]};
      end else begin
        pos = chunk_cnt;
        place = (chunk_cnt == 0) ? {32'b0, heap_base_r}
                                 : {32'b0, chunk_addr[chunk_cnt-1]} + {32'b0, chunk_len[chunk_cnt-1]};
      end
    end
    for (int j = chunk_cnt; j > pos; j--) begin
      chunk_addr[j] = chunk_addr[j-1];
      chunk_len[j] = chunk_len[j-1];
    end
    chunk_addr[pos] = place[31:0];
    chunk_len[pos] = need[31:0];
    chunk_cnt++;
    free_bytes = ({32'b0, free_bytes} > need) ? free_bytes - need[31:0] : 32'd0;
    res.status = ST_ALLOCATED;
    res.chunk_addr = place[31:0];
    return res;
  endfunction

  task automatic push_request(logic kind, logic [31:0] size, logic [31:0] addr);
    request_t r;
    reply_t   p;
    r = '{kind: kind, size: size, addr: addr};
    p = predict_allocator(r);
    pending_q = {pending_q, r};
    reply_q = {reply_q, p};
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || reply_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    drain();
    @(posedge clk);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_penable <= 0;
    cfg_paddr <= {idx[0], 2'b00}; cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    if (idx == CFG_HEAP_BASE) heap_base_r = value;
    else heap_size_r = value;
    chunk_cnt = 0;
    free_bytes = heap_size_r;
    config_writes++;
  endtask

  task automatic random_phase(int n, int alloc_pct, int max_size);
    logic [31:0] sz;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < alloc_pct) begin
        case ($urandom_range(19))
          0: sz = $urandom;
          1: sz = 32'hFFFF_FFFF - $urandom_range(4);
          default: sz = $urandom_range(max_size);
        endcase
        push_request(REQ_ALLOC, sz, $urandom);
      end else if (chunk_cnt > 0 && $urandom_range(9) < 8) begin
        push_request(REQ_FREE, $urandom, chunk_addr[$urandom_range(chunk_cnt - 1)]);
      end else begin
        push_request(REQ_FREE, $urandom, $urandom);
      end
    end
  endtask

  // request driver
  int burst_left, gap_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 0;
      in_tdata <= '0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_tvalid && in_tready) void'(pending_q.pop_front());
      if (in_tvalid && !in_tready) begin
      end else if (gap_left > 0) begin
        in_tvalid <= 0;
        gap_left--;
      end else if (pending_q.size() != 0) begin
        in_tvalid <= 1;
        in_tdata <= {7'b0, pending_q[0].addr, pending_q[0].size, pending_q[0].kind};
        if (burst_left == 0) burst_left = $urandom_range(1, 20);
        burst_left--;
        if (burst_left == 0) gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 30);
      end else begin
        in_tvalid <= 0;
      end
    end
  end

  // result stall pattern
  int cyc, hold_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 0;
      cyc = 0;
      hold_left = 0;
    end else begin
      cyc++;
      if (long_hold_req && hold_left == 0) hold_left = 3000;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 0;
      end else if ((cyc / 700) % 3 == 0) begin
        out_tready <= 1;
      end else begin
        out_tready <= ($urandom_range(99) < 60);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (reply_q.size() == 0) begin
        $error("unexpected result %h", out_tdata);
        fail = 1;
      end else begin
        want = reply_q.pop_front();
        if (out_tdata[2:0] != want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tdata[2:0]);
          fail = 1;
        end
        if (out_tdata[34:3] != want.chunk_addr) begin
          $error("chunk_address: expected %h, got %h", want.chunk_addr, out_tdata[34:3]);
          fail = 1;
        end
        if (out_tdata[66:35] != want.freed) begin
          $error("freed_bytes: expected %h, got %h", want.freed, out_tdata[66:35]);
          fail = 1;
        end
        if (want.status <= ST_NOT_FOUND) status_seen[want.status]++;
      end
    end
  end

  initial begin
    #50_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_n = 0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = 0; cfg_pwdata = 0;
    long_hold_req = 0;
    heap_base_r = 0; heap_size_r = 0; chunk_cnt = 0; free_bytes = 0;
    config_writes = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;

    // empty heap out of reset
    push_request(REQ_ALLOC, 0, 0);
    push_request(REQ_ALLOC, 4, 0);
    push_request(REQ_FREE, 0, 0);
    push_request(REQ_FREE, 0, 32'h1234);

    write_reg(CFG_HEAP_BASE, 32'h0000_1000);
    write_reg(CFG_HEAP_SIZE, 32'h0000_0100);
    push_request(REQ_ALLOC, 0, 0);
    push_request(REQ_ALLOC, 1, 0);
    push_request(REQ_ALLOC, 3, 0);
    push_request(REQ_ALLOC, 32'hFFFF_FFFF, 0);
    push_request(REQ_ALLOC, 32'hFFFF_FFFC, 0);
    push_request(REQ_ALLOC, 8, 0);
    push_request(REQ_FREE, 0, 32'h0000_1000);
    push_request(REQ_FREE, 0, 32'h0000_DEAD);
    push_request(REQ_ALLOC, 16, 0);
    push_request(REQ_FREE, 0, 32'h0000_1004);
    push_request(REQ_ALLOC, 2, 0);
    push_request(REQ_ALLOC, 32'h0000_0100, 0);
    push_request(REQ_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_request(REQ_ALLOC, 32'h0000_00B0, 32'hFFFF_FFFF);
    for (int i = 0; i < 66; i++) push_request(REQ_ALLOC, 0, 0);

    // wraparound at the top of the address space
    write_reg(CFG_HEAP_BASE, 32'hFFFF_FF00);
    write_reg(CFG_HEAP_SIZE, 32'h0000_1000);
    random_phase(250, 60, 300);

    write_reg(CFG_HEAP_BASE, 32'h0000_0000);
    write_reg(CFG_HEAP_SIZE, 32'hFFFF_FFFF);
    random_phase(250, 55, 5000);

    write_reg(CFG_HEAP_BASE, $urandom & 32'hFFFF_FFFC);
    write_reg(CFG_HEAP_SIZE, 32'h0000_1000);
    random_phase(400, 60, 200);
    long_hold_req <= 1;
    @(posedge clk);
    long_hold_req <= 0;

    write_reg(CFG_HEAP_BASE, $urandom);
    write_reg(CFG_HEAP_SIZE, $urandom_range(2000));
    random_phase(300, 55, 120);

    write_reg(CFG_HEAP_SIZE, 32'h0000_0000);
    random_phase(60, 70, 8);

    write_reg(CFG_HEAP_BASE, 32'hFFFF_FFFF);
    write_reg(CFG_HEAP_SIZE, 32'h0001_0000);
    random_phase(400, 75, 400);

    write_reg(CFG_HEAP_BASE, $urandom & 32'hFFFF_FFFC);
    write_reg(CFG_HEAP_SIZE, 32'h0000_4000);
    random_phase(350, 58, 600);

    drain();
    repeat (500) @(posedge clk);
    $display("Covered %0d register writes; allocated %0d, freed %0d, table full %0d,",
             config_writes, status_seen[ST_ALLOCATED], status_seen[ST_FREED],
             status_seen[ST_FULL]);
    $display("no space %0d, address not found %0d.", status_seen[ST_NO_SPACE],
             status_seen[ST_NOT_FOUND]);
    if (!fail) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
